// ===== rtl/fatlb_pkg.sv =====
// Shared constants and types for the fully associative LRU TLB.
// No dependencies; used by every module of the block by scoped name.
package fatlb_pkg;

    // Structural defaults handed to the top-level parameters
    localparam int MAX_ENTRIES_DEF  = 128;
    localparam int ADDRESS_BITS_DEF = 32;

    // Configuration register layout
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_BITS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENTRIES_IN_USE = 1'b1;

    localparam int OFFSET_W = 5;
    localparam int ENTRIES_W = 8;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 5'd12;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 8'd128;

    // Smallest page offset; fixes the widest page number
    localparam int OFFSET_MIN  = 5;
    localparam int ENTRIES_MIN = 2;

    // Running counters
    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Sequencer to compare unit control
    typedef struct packed {
        logic clr;     // start of a new lookup
        logic step;    // one entry's read data is present
        logic in_use;  // that entry takes part in lookup and replacement
    } t_scan_ctl;

endpackage

// ===== rtl/fully_assoc_lru_tlb_sim_top.sv =====
// Fully associative LRU TLB: sequencer, configuration, counters, result stage.
// Depends on fatlb_pkg, fatlb_store and fatlb_cmp.
//
// Each accepted address is looked up by one sweep over all MAX_ENTRIES
// entries through a single tag/recency memory read port and one shared
// compare unit, one entry per cycle. The sweep (S_SCAN) reads the entries
// through the registered read port; the finish step (S_FIN) then updates
// the entry and loads the result register, and the sequencer returns to
// idle. A new transfer is accepted only in idle, so each item is finished
// before the next is taken. The recency update of one access is applied
// during the sweep of the next one. The input stalls for the whole lookup;
// a finished result waits in the output register without blocking the next
// transfer, but the update step of the following item waits while that
// register is still held.
// No clearing pass follows reset: valid bits cover the table.
// Configuration: index 0 offset_bits (5 bits, below 5 acts as 5),
// index 1 entries_in_use (8 bits, clamped to 2..MAX_ENTRIES).
module fully_assoc_lru_tlb_sim_top #(
    parameter int MAX_ENTRIES  = fatlb_pkg::MAX_ENTRIES_DEF,
    parameter int ADDRESS_BITS = fatlb_pkg::ADDRESS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [fatlb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fatlb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ADDRESS_BITS-1:0]          i_address,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_hit,
    output logic [fatlb_pkg::COUNT_W-1:0]    o_hit_count,
    output logic [fatlb_pkg::COUNT_W-1:0]    o_miss_count
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > fatlb_pkg::ENTRIES_W) ? CNT_W : fatlb_pkg::ENTRIES_W;
    localparam int PAGE_W = ADDRESS_BITS - fatlb_pkg::OFFSET_MIN;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                           r_state;
    logic [fatlb_pkg::OFFSET_W-1:0]   r_offset;
    logic [fatlb_pkg::ENTRIES_W-1:0]  r_entries;
    logic [PAGE_W-1:0]                r_page;
    logic [CNT_W-1:0]                 r_cnt;
    logic [fatlb_pkg::COUNT_W-1:0]    r_hits, r_misses;
    logic                             r_out_vld, r_out_hit;
    logic [fatlb_pkg::COUNT_W-1:0]    r_out_hits, r_out_misses;

    logic [fatlb_pkg::COUNT_W-1:0]    n_hits, n_misses;
    logic [fatlb_pkg::OFFSET_W-1:0]   shift;
    logic [ADDRESS_BITS-1:0]          shifted;
    logic [CMP_W-1:0]                 ent_ext;
    logic [CNT_W-1:0]                 n_use;
    logic                             in_xfer, fin_go;
    fatlb_pkg::t_scan_ctl             scan_ctl;

    logic             q_vld, q_valid, found;
    logic [IDX_W-1:0] q_idx, q_rank, slot, slot_rank;
    logic [PAGE_W-1:0] q_tag;

    assign in_xfer = i_in_valid && !o_in_stall;
    assign fin_go  = (r_state == S_FIN) && (!r_out_vld || !i_out_stall);

    // Page number from the effective offset
    assign shift   = (r_offset < fatlb_pkg::OFFSET_W'(fatlb_pkg::OFFSET_MIN))
                   ? fatlb_pkg::OFFSET_W'(fatlb_pkg::OFFSET_MIN) : r_offset;
    assign shifted = i_address >> shift;

    // Entry count in use, clamped
    assign ent_ext = CMP_W'(r_entries);
    always_comb begin
        priority if (ent_ext < CMP_W'(fatlb_pkg::ENTRIES_MIN)) begin
            n_use = CNT_W'(fatlb_pkg::ENTRIES_MIN);
        end else if (ent_ext > CMP_W'(MAX_ENTRIES)) begin
            n_use = CNT_W'(MAX_ENTRIES);
        end else begin
            n_use = CNT_W'(ent_ext);
        end
    end

    // Saturating counters for the access being finished
    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (found) begin
            if (r_hits != fatlb_pkg::COUNT_MAX) n_hits = r_hits + 1'b1;
        end else begin
            if (r_misses != fatlb_pkg::COUNT_MAX) n_misses = r_misses + 1'b1;
        end
    end

    assign scan_ctl.clr    = in_xfer;
    assign scan_ctl.step   = q_vld;
    assign scan_ctl.in_use = CNT_W'(q_idx) < n_use;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= fatlb_pkg::OFFSET_RESET;
            r_entries <= fatlb_pkg::ENTRIES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fatlb_pkg::CFG_IDX_OFFSET_BITS: begin
                    r_offset <= i_cfg_data[fatlb_pkg::OFFSET_W-1:0];
                end
                fatlb_pkg::CFG_IDX_ENTRIES_IN_USE: begin
                    r_entries <= i_cfg_data[fatlb_pkg::ENTRIES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // result held until transferred, reloaded by the finish step
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_page  <= shifted[PAGE_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MAX_ENTRIES)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_hits       <= n_hits;
                        r_misses     <= n_misses;
                        r_out_hit    <= found;
                        r_out_hits   <= n_hits;
                        r_out_misses <= n_misses;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    fatlb_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .PAGE_W      (PAGE_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      ((r_state == S_SCAN) && (r_cnt < CNT_W'(MAX_ENTRIES))),
        .i_rd_idx     (r_cnt[IDX_W-1:0]),
        .o_q_vld      (q_vld),
        .o_q_idx      (q_idx),
        .o_q_tag      (q_tag),
        .o_q_valid    (q_valid),
        .o_q_rank     (q_rank),
        .i_wr_en      (fin_go && !found),
        .i_wr_idx     (slot),
        .i_wr_tag     (r_page),
        .i_touch_set  (fin_go),
        .i_touch_idx  (slot),
        .i_touch_rank (slot_rank)
    );

    fatlb_cmp #(
        .IDX_W  (IDX_W),
        .PAGE_W (PAGE_W)
    ) u_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_page      (r_page),
        .i_idx       (q_idx),
        .i_tag       (q_tag),
        .i_valid     (q_valid),
        .i_rank      (q_rank),
        .o_found     (found),
        .o_slot      (slot),
        .o_slot_rank (slot_rank)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_hit        = r_out_hit;
    assign o_hit_count  = r_out_hits;
    assign o_miss_count = r_out_misses;

    // A transfer always starts a sweep
    a_xfer_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN))
        else $error("input transfer did not start a sweep");

    // No sweep read is issued outside the sweep
    a_no_stray_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCAN) |=> !q_vld)
        else $error("memory read outside sweep");

    // Counters never go backwards
    a_counts_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_hits >= $past(r_hits)) && (r_misses >= $past(r_misses)))
        else $error("running count decreased");

    // A result appears only when an access finishes
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside finish step");

endmodule

// ===== rtl/fatlb_store.sv =====
// Entry store: tag and recency memories, per-entry valid bits and the
// deferred recency update that is folded into each sweep. Uses fatlb_pkg.
module fatlb_store #(
    parameter int MAX_ENTRIES = fatlb_pkg::MAX_ENTRIES_DEF,
    parameter int PAGE_W      = fatlb_pkg::ADDRESS_BITS_DEF - fatlb_pkg::OFFSET_MIN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sweep read port
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_rd_idx,
    output logic                           o_q_vld,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_q_idx,
    output logic [PAGE_W-1:0]              o_q_tag,
    output logic                           o_q_valid,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_q_rank,
    // tag fill on a miss
    input  logic                           i_wr_en,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_wr_idx,
    input  logic [PAGE_W-1:0]              i_wr_tag,
    // recency update to apply during the next sweep
    input  logic                           i_touch_set,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_touch_idx,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_touch_rank
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    logic [PAGE_W-1:0] r_tag_mem  [MAX_ENTRIES];
    logic [IDX_W-1:0]  r_rank_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] r_rank_ok;   // rank entry written since reset

    logic              r_q_vld;
    logic [IDX_W-1:0]  r_q_idx;
    logic [PAGE_W-1:0] r_q_tag;
    logic              r_q_valid;
    logic [IDX_W-1:0]  r_q_rank;
    logic              r_q_ok;

    logic              r_pend_vld;
    logic [IDX_W-1:0]  r_pend_idx;
    logic [IDX_W-1:0]  r_pend_rank;

    logic [IDX_W-1:0]  raw_rank;
    logic [IDX_W-1:0]  cor_rank;

    // An unwritten rank reads as the entry's own index
    assign raw_rank = r_q_ok ? r_q_rank : r_q_idx;

    // Pending touch: the touched entry goes to rank zero, younger ones age
    always_comb begin
        cor_rank = raw_rank;
        if (r_pend_vld) begin
            if (r_q_idx == r_pend_idx) begin
                cor_rank = '0;
            end else if (raw_rank < r_pend_rank) begin
                cor_rank = raw_rank + 1'b1;
            end
        end
    end

    // Memory read, rank write-back and tag fill
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q_tag  <= r_tag_mem[i_rd_idx];
            r_q_rank <= r_rank_mem[i_rd_idx];
        end
        if (r_q_vld) begin
            r_rank_mem[r_q_idx] <= cor_rank;
        end
        if (i_wr_en) begin
            r_tag_mem[i_wr_idx] <= i_wr_tag;
        end
    end

    // Control state: valid bits, read pipeline, pending touch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rank_ok   <= '0;
            r_q_vld     <= 1'b0;
            r_q_idx     <= '0;
            r_q_valid   <= 1'b0;
            r_q_ok      <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_pend_idx  <= '0;
            r_pend_rank <= '0;
        end else begin
            r_q_vld <= i_rd_en;
            if (i_rd_en) begin
                r_q_idx   <= i_rd_idx;
                r_q_valid <= r_valid[i_rd_idx];
                r_q_ok    <= r_rank_ok[i_rd_idx];
            end
            if (r_q_vld) begin
                r_rank_ok[r_q_idx] <= 1'b1;
            end
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_touch_set) begin
                r_pend_vld  <= 1'b1;
                r_pend_idx  <= i_touch_idx;
                r_pend_rank <= i_touch_rank;
            end
        end
    end

    assign o_q_vld   = r_q_vld;
    assign o_q_idx   = r_q_idx;
    assign o_q_tag   = r_q_tag;
    assign o_q_valid = r_q_valid;
    assign o_q_rank  = cor_rank;

endmodule

// ===== rtl/fatlb_cmp.sv =====
// Shared compare unit: one entry per step, tracking the first hit, the
// first empty entry and the oldest entry in use. Uses fatlb_pkg.
module fatlb_cmp #(
    parameter int IDX_W  = $clog2(fatlb_pkg::MAX_ENTRIES_DEF),
    parameter int PAGE_W = fatlb_pkg::ADDRESS_BITS_DEF - fatlb_pkg::OFFSET_MIN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fatlb_pkg::t_scan_ctl  i_ctl,
    input  logic [PAGE_W-1:0]     i_page,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [PAGE_W-1:0]     i_tag,
    input  logic                  i_valid,
    input  logic [IDX_W-1:0]      i_rank,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_slot,
    output logic [IDX_W-1:0]      o_slot_rank
);

    logic             r_found, r_empty, r_old_seen;
    logic [IDX_W-1:0] r_hit_idx, r_hit_rank;
    logic [IDX_W-1:0] r_emp_idx, r_emp_rank;
    logic [IDX_W-1:0] r_old_idx, r_old_rank;

    logic take;
    assign take = i_ctl.step && i_ctl.in_use;

    // Scan trackers; first match wins, strictly greater rank replaces
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_found    <= 1'b0;
            r_empty    <= 1'b0;
            r_old_seen <= 1'b0;
        end else if (take) begin
            if (!r_found && i_valid && (i_tag == i_page)) begin
                r_found <= 1'b1;
            end
            if (!r_empty && !i_valid) begin
                r_empty <= 1'b1;
            end
            if (!r_old_seen || (i_rank > r_old_rank)) begin
                r_old_seen <= 1'b1;
            end
        end
    end

    // Payload captured alongside the trackers
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (!r_found && i_valid && (i_tag == i_page)) begin
                r_hit_idx  <= i_idx;
                r_hit_rank <= i_rank;
            end
            if (!r_empty && !i_valid) begin
                r_emp_idx  <= i_idx;
                r_emp_rank <= i_rank;
            end
            if (!r_old_seen || (i_rank > r_old_rank)) begin
                r_old_idx  <= i_idx;
                r_old_rank <= i_rank;
            end
        end
    end

    // Slot choice: hit, else first empty entry, else least recent
    always_comb begin
        priority if (r_found) begin
            o_slot      = r_hit_idx;
            o_slot_rank = r_hit_rank;
        end else if (r_empty) begin
            o_slot      = r_emp_idx;
            o_slot_rank = r_emp_rank;
        end else begin
            o_slot      = r_old_idx;
            o_slot_rank = r_old_rank;
        end
    end

    assign o_found = r_found;

endmodule
